FILE: rtl/core/sorted_set_insert_rank_query_macros.svh
// Assertion macros shared by the block's checking code.
`ifndef SORTED_SET_INSERT_RANK_QUERY_MACROS_SVH
`define SORTED_SET_INSERT_RANK_QUERY_MACROS_SVH

// Checked on every clock edge outside reset.
`define SSIRQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SSIRQ_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/ssirq_pkg.sv
package ssirq_pkg;

	localparam int CAPACITY_DEFAULT = 256;
	localparam int KEY_W = 32;
	localparam int RANK_W = 9;
	localparam int STATUS_W = 3;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FULL = 3'd2,
		ST_FOUND = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	typedef struct packed {
		logic cmp_en;
		logic ins_en;
	} cell_ctrl_t;

endpackage

FILE: rtl/core/ssirq_cell.sv
module ssirq_cell
	import ssirq_pkg::*;
#(
	parameter int IDX = 0,
	parameter int CW = 9
) (
	input logic clk,
	input cell_ctrl_t ctrl,
	input logic signed [KEY_W-1:0] in_key,
	input logic signed [KEY_W-1:0] new_key,
	input logic [CW-1:0] count,
	input logic signed [KEY_W-1:0] left_key,
	input logic left_lt,
	output logic signed [KEY_W-1:0] key_q,
	output logic lt_s1,
	output logic eq_s1
);

	logic occupied;

	assign occupied = CW'(IDX) < count;

	always_ff @(posedge clk) begin
		if (ctrl.cmp_en) begin
			lt_s1 <= occupied && (key_q < in_key);
			eq_s1 <= occupied && (key_q == in_key);
		end
		if (ctrl.ins_en && !lt_s1) begin
			key_q <= left_lt ? new_key : left_key;
		end
	end

endmodule

FILE: rtl/core/sorted_set_insert_rank_query.sv
// Result: done rises at the clock edge after the transfer edge. A new item is not taken while
// busy is high; the cell row compares at the transfer edge and, for an insert, shifts at the
// next, so busy stays high for the cycle after each transfer.
// Reset: arst_n clears the key count and the control state; the key cells are not cleared.
// The receiver cannot stall: each result stands on status and rank while done is high.
module sorted_set_insert_rank_query
	import ssirq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic func,
	input logic signed [KEY_W-1:0] key,
	output logic done,
	output logic [STATUS_W-1:0] status,
	output logic [RANK_W-1:0] rank
);

	`include "sorted_set_insert_rank_query_macros.svh"

	localparam int CW = $clog2(CAPACITY + 1);

	logic busy_q;
	logic done_q;
	status_t status_q;
	logic [RANK_W-1:0] rank_q;
	logic [CW-1:0] count_q;
	logic func_s1;
	logic signed [KEY_W-1:0] key_s1;

	logic accept;
	logic present;
	logic full;
	logic ins_done;
	logic [CW-1:0] hit_pos;
	cell_ctrl_t ctrl;

	logic signed [KEY_W-1:0] cell_key [CAPACITY];
	logic [CAPACITY-1:0] lt_vec;
	logic [CAPACITY-1:0] eq_vec;

	assign accept = start && !busy_q;
	assign present = |eq_vec;
	assign full = count_q == CW'(CAPACITY);
	assign ctrl.cmp_en = accept;
	assign ctrl.ins_en = busy_q && (func_s1 == FUNC_INSERT) && !present && !full;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [KEY_W-1:0] left_key;
		logic left_lt;
		if (i == 0) begin : g_head
			assign left_key = key_s1;
			assign left_lt = 1'b1;
		end else begin : g_body
			assign left_key = cell_key[i-1];
			assign left_lt = lt_vec[i-1];
		end
		ssirq_cell #(
			.IDX(i),
			.CW(CW)
		) u_cell (
			.clk(clk),
			.ctrl(ctrl),
			.in_key(key),
			.new_key(key_s1),
			.count(count_q),
			.left_key(left_key),
			.left_lt(left_lt),
			.key_q(cell_key[i]),
			.lt_s1(lt_vec[i]),
			.eq_s1(eq_vec[i])
		);
	end

	always_comb begin
		hit_pos = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (eq_vec[i]) begin
				hit_pos = hit_pos | CW'(i + 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= func;
			key_s1 <= key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			count_q <= '0;
			status_q <= ST_INSERTED;
			rank_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (accept) begin
				busy_q <= 1'b1;
			end
			if (busy_q) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
				rank_q <= '0;
				if (func_s1 == FUNC_INSERT) begin
					if (present) begin
						status_q <= ST_DUPLICATE;
					end else if (full) begin
						status_q <= ST_FULL;
					end else begin
						status_q <= ST_INSERTED;
						count_q <= count_q + CW'(1);
					end
				end else begin
					if (present) begin
						status_q <= ST_FOUND;
						rank_q <= RANK_W'(hit_pos);
					end else begin
						status_q <= ST_NOT_FOUND;
					end
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign status = status_q;
	assign rank = rank_q;
	assign ins_done = done_q && (status_q == ST_INSERTED);

	`SSIRQ_ASSERT(a_busy_then_done, busy |=> done, "result did not follow the busy cycle")
	`SSIRQ_ASSERT(a_done_single, done |=> !done, "result strobe held for more than one cycle")
	`SSIRQ_ASSERT(a_count_bound, count_q <= CW'(CAPACITY), "key count beyond capacity")
	`SSIRQ_ASSERT(a_ins_count, ins_done |-> count_q == $past(count_q) + CW'(1), "count not stepped")
	`SSIRQ_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !done && !busy, "activity during reset")

endmodule
